// ===== sv/sdrne_pkg.sv =====
// ----------------------------------------------------------------------------
// sdrne_pkg
// Shared constants and types for the rounded signed divider pipeline.
// ----------------------------------------------------------------------------
package sdrne_pkg;

  // Default operand width in bits
  localparam int SDRNE_OPERAND_WIDTH = 32;

  // Sign and error flags that travel with each word down the pipeline
  typedef struct packed {
    logic neg_q;   // quotient takes a negative sign
    logic neg_r;   // remainder takes the dividend's sign
    logic dz;      // divisor was zero
  } sdrne_flags_t;

endpackage

// ===== sv/sdrne_pre.sv =====
// ----------------------------------------------------------------------------
// sdrne_pre
// Entry stage: splits both operands into sign and magnitude and flags a
// zero divisor.
// ----------------------------------------------------------------------------
module sdrne_pre
  import sdrne_pkg::*;
#(
  parameter int OPERAND_WIDTH = SDRNE_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  logic [OPERAND_WIDTH-1:0] dividend,
  input  logic [OPERAND_WIDTH-1:0] divisor,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output sdrne_flags_t             flags_out,
  output logic [OPERAND_WIDTH-1:0] amag_out,
  output logic [OPERAND_WIDTH-1:0] bmag_out
);

  logic                     valid_r;
  sdrne_flags_t             flags_r, flags_nxt;
  logic [OPERAND_WIDTH-1:0] amag_r, amag_nxt;
  logic [OPERAND_WIDTH-1:0] bmag_r, bmag_nxt;
  logic                     sign_a, sign_b;

  assign up_ready = !valid_r || dn_ready;

  // Take magnitudes; the most negative value maps to its unsigned magnitude
  always_comb begin
    sign_a          = dividend[OPERAND_WIDTH-1];
    sign_b          = divisor[OPERAND_WIDTH-1];
    amag_nxt        = sign_a ? (~dividend + 1'b1) : dividend;
    bmag_nxt        = sign_b ? (~divisor + 1'b1) : divisor;
    flags_nxt.neg_q = sign_a ^ sign_b;
    flags_nxt.neg_r = sign_a;
    flags_nxt.dz    = (divisor == '0);
  end

  // Hold or advance the stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Load payload on an accepted word
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      flags_r <= flags_nxt;
      amag_r  <= amag_nxt;
      bmag_r  <= bmag_nxt;
    end
  end

  assign dn_valid  = valid_r;
  assign flags_out = flags_r;
  assign amag_out  = amag_r;
  assign bmag_out  = bmag_r;

endmodule

// ===== sv/sdrne_div_stage.sv =====
// ----------------------------------------------------------------------------
// sdrne_div_stage
// One restoring division step: shifts in one dividend bit, trial-subtracts
// the divisor magnitude and shifts the resulting quotient bit in.
// ----------------------------------------------------------------------------
module sdrne_div_stage
  import sdrne_pkg::*;
#(
  parameter int OPERAND_WIDTH = SDRNE_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  sdrne_flags_t             flags_in,
  input  logic [OPERAND_WIDTH-1:0] aq_in,     // dividend bits above, quotient bits below
  input  logic [OPERAND_WIDTH-1:0] rem_in,
  input  logic [OPERAND_WIDTH-1:0] bmag_in,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output sdrne_flags_t             flags_out,
  output logic [OPERAND_WIDTH-1:0] aq_out,
  output logic [OPERAND_WIDTH-1:0] rem_out,
  output logic [OPERAND_WIDTH-1:0] bmag_out
);

  logic                     valid_r;
  sdrne_flags_t             flags_r;
  logic [OPERAND_WIDTH-1:0] aq_r, aq_nxt;
  logic [OPERAND_WIDTH-1:0] rem_r, rem_nxt;
  logic [OPERAND_WIDTH-1:0] bmag_r;
  logic [OPERAND_WIDTH:0]   rem_sh;
  logic [OPERAND_WIDTH:0]   diff;
  logic                     qbit;

  assign up_ready = !valid_r || dn_ready;

  // Trial subtract; keep the difference when it does not go negative
  always_comb begin
    rem_sh  = {rem_in, aq_in[OPERAND_WIDTH-1]};
    diff    = rem_sh - {1'b0, bmag_in};
    qbit    = (rem_sh >= {1'b0, bmag_in});
    rem_nxt = qbit ? diff[OPERAND_WIDTH-1:0] : rem_sh[OPERAND_WIDTH-1:0];
    aq_nxt  = {aq_in[OPERAND_WIDTH-2:0], qbit};
  end

  // Hold or advance the stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Load payload on an accepted word
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      flags_r <= flags_in;
      aq_r    <= aq_nxt;
      rem_r   <= rem_nxt;
      bmag_r  <= bmag_in;
    end
  end

  assign dn_valid  = valid_r;
  assign flags_out = flags_r;
  assign aq_out    = aq_r;
  assign rem_out   = rem_r;
  assign bmag_out  = bmag_r;

endmodule

// ===== sv/sdrne_post.sv =====
// ----------------------------------------------------------------------------
// sdrne_post
// Rounding and sign stages: decides half-even rounding on the truncated
// magnitudes, then applies signs into the output register.
// ----------------------------------------------------------------------------
module sdrne_post
  import sdrne_pkg::*;
#(
  parameter int OPERAND_WIDTH = SDRNE_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  sdrne_flags_t             flags_in,
  input  logic [OPERAND_WIDTH-1:0] qmag_in,
  input  logic [OPERAND_WIDTH-1:0] rmag_in,
  input  logic [OPERAND_WIDTH-1:0] bmag_in,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output logic [OPERAND_WIDTH:0]   quotient,
  output logic [OPERAND_WIDTH-1:0] remainder,
  output logic                     div_by_zero
);

  // Round stage
  logic                     valid_a_r;
  logic                     ready_a;
  sdrne_flags_t             flags_a_r;
  logic [OPERAND_WIDTH:0]   qm_r, qm_nxt;
  logic [OPERAND_WIDTH:0]   rm_r, rm_nxt;
  logic [OPERAND_WIDTH:0]   two_r;
  logic                     rnd;

  // Sign stage (output register)
  logic                     valid_b_r;
  logic                     ready_b;
  logic [OPERAND_WIDTH:0]   quot_r, quot_nxt;
  logic [OPERAND_WIDTH-1:0] rem_r, rem_nxt;
  logic [OPERAND_WIDTH:0]   rem_signed;
  logic                     dz_r;

  assign ready_b  = !valid_b_r || dn_ready;
  assign ready_a  = !valid_a_r || ready_b;
  assign up_ready = ready_a;

  // Step away from zero when the remainder passes half the divisor,
  // or sits exactly at half with an odd truncated quotient
  always_comb begin
    two_r  = {rmag_in, 1'b0};
    rnd    = (two_r > {1'b0, bmag_in}) ||
             ((two_r == {1'b0, bmag_in}) && qmag_in[0]);
    qm_nxt = rnd ? ({1'b0, qmag_in} + 1'b1) : {1'b0, qmag_in};
    rm_nxt = rnd ? ({1'b0, rmag_in} - {1'b0, bmag_in}) : {1'b0, rmag_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (ready_a) begin
      valid_a_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && ready_a) begin
      flags_a_r <= flags_in;
      qm_r      <= qm_nxt;
      rm_r      <= rm_nxt;
    end
  end

  // Apply signs; force zeros on a zero divisor
  always_comb begin
    rem_signed = flags_a_r.neg_r ? (~rm_r + 1'b1) : rm_r;
    quot_nxt   = flags_a_r.neg_q ? (~qm_r + 1'b1) : qm_r;
    rem_nxt    = rem_signed[OPERAND_WIDTH-1:0];
    if (flags_a_r.dz) begin
      quot_nxt = '0;
      rem_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (ready_b) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_a_r && ready_b) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
      dz_r   <= flags_a_r.dz;
    end
  end

  assign dn_valid    = valid_b_r;
  assign quotient    = quot_r;
  assign remainder   = rem_r;
  assign div_by_zero = dz_r;

endmodule

// ===== sv/signed_div_round_nearest_even.sv =====
// ----------------------------------------------------------------------------
// signed_div_round_nearest_even
// Pipelined signed divider, quotient rounded to nearest with ties to even.
// ----------------------------------------------------------------------------
// Accepts one dividend/divisor word per cycle and returns one result word per
// cycle while out_tready does not stall the output, quotient rounded to nearest
// (ties to even) with remainder dividend - divisor * quotient. Each word passes
// one entry stage for magnitudes, one restoring-division stage per quotient
// bit, a rounding stage and the output register. Each stage has its own valid
// and advances whenever the next stage is empty or moving, so bubbles close up
// and a stalled output only blocks the input once the whole pipeline is full.
// A zero divisor returns zero quotient and remainder with out_tuser set.
module signed_div_round_nearest_even
  import sdrne_pkg::*;
#(
  parameter int OPERAND_WIDTH = SDRNE_OPERAND_WIDTH,
  localparam int InDataW  = ((2 * OPERAND_WIDTH + 7) / 8) * 8,
  localparam int OutDataW = ((2 * OPERAND_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // dividend, divisor
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // quotient, remainder, zero pad
  output logic                out_tuser   // div_by_zero
);

  localparam int NStages = OPERAND_WIDTH;

  // Stage chain, index 0 is the entry stage output
  logic                     valid_s [0:NStages];
  logic                     ready_s [0:NStages];
  sdrne_flags_t             flags_s [0:NStages];
  logic [OPERAND_WIDTH-1:0] aq_s    [0:NStages];
  logic [OPERAND_WIDTH-1:0] rem_s   [0:NStages];
  logic [OPERAND_WIDTH-1:0] bmag_s  [0:NStages];

  logic [OPERAND_WIDTH:0]   quotient;
  logic [OPERAND_WIDTH-1:0] remainder;
  logic                     div_by_zero;

  // Split operands into magnitude and sign
  sdrne_pre #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_tvalid),
    .up_ready  (in_tready),
    .dividend  (in_tdata[OPERAND_WIDTH-1:0]),
    .divisor   (in_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH]),
    .dn_valid  (valid_s[0]),
    .dn_ready  (ready_s[0]),
    .flags_out (flags_s[0]),
    .amag_out  (aq_s[0]),
    .bmag_out  (bmag_s[0])
  );

  // Partial remainder starts at zero
  assign rem_s[0] = '0;

  // One restoring step per quotient bit
  for (genvar i = 0; i < NStages; i++) begin : g_div
    sdrne_div_stage #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (valid_s[i]),
      .up_ready  (ready_s[i]),
      .flags_in  (flags_s[i]),
      .aq_in     (aq_s[i]),
      .rem_in    (rem_s[i]),
      .bmag_in   (bmag_s[i]),
      .dn_valid  (valid_s[i+1]),
      .dn_ready  (ready_s[i+1]),
      .flags_out (flags_s[i+1]),
      .aq_out    (aq_s[i+1]),
      .rem_out   (rem_s[i+1]),
      .bmag_out  (bmag_s[i+1])
    );
  end

  // Round and apply signs
  sdrne_post #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (valid_s[NStages]),
    .up_ready    (ready_s[NStages]),
    .flags_in    (flags_s[NStages]),
    .qmag_in     (aq_s[NStages]),
    .rmag_in     (rem_s[NStages]),
    .bmag_in     (bmag_s[NStages]),
    .dn_valid    (out_tvalid),
    .dn_ready    (out_tready),
    .quotient    (quotient),
    .remainder   (remainder),
    .div_by_zero (div_by_zero)
  );

  // Pack the result word, zero pad on top
  assign out_tdata = OutDataW'({remainder, quotient});
  assign out_tuser = div_by_zero;

endmodule

// ===== sv/sdrne_checker.sv =====
// ----------------------------------------------------------------------------
// sdrne_checker
// Port-level checks for the rounded signed divider, bound to the top level.
// ----------------------------------------------------------------------------
module sdrne_checker
  import sdrne_pkg::*;
#(
  parameter int OPERAND_WIDTH = SDRNE_OPERAND_WIDTH,
  localparam int OutDataW = ((2 * OPERAND_WIDTH + 1 + 7) / 8) * 8
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tuser
);

  // Pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  // An empty output register means every stage can take a word
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output stage");

  // Zero divisor returns zero quotient and remainder
  a_zero_div_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("nonzero result on divide by zero");

  // Padding above the packed fields stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OutDataW-1:2*OPERAND_WIDTH+1] == '0)
    else $error("padding bits set in out_tdata");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule

bind signed_div_round_nearest_even sdrne_checker #(
  .OPERAND_WIDTH(OPERAND_WIDTH)
) u_sdrne_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
